@@ rtl/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
// No dependencies; used by every module of the block.
package utf8d_pkg;

   localparam int BYTE_W  = 8;
   localparam int UNIT_W  = 16;
   localparam int CP_W    = 21;
   localparam int CNT_W   = 2;
   localparam int TDATA_IN_W  = 8;
   localparam int TDATA_OUT_W = 16;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [UNIT_W-1:0] REPL_RESET = 16'h003F;

   localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
   localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF4;
   localparam logic [BYTE_W-1:0] CONT_LO    = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_HI    = 8'hBF;
   localparam logic [BYTE_W-1:0] E0_LO      = 8'hA0;
   localparam logic [BYTE_W-1:0] F0_LO      = 8'h90;
   localparam logic [BYTE_W-1:0] F4_HI      = 8'h8F;

   localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h10000;
   localparam logic [UNIT_W-1:0] HI_SURR    = 16'hD800;
   localparam logic [UNIT_W-1:0] LO_SURR    = 16'hDC00;

   typedef struct packed {
      logic              stream_end;
      logic              run_last;
      logic [UNIT_W-1:0] code_unit;
   } entry_type;

   // units produced by one accepted byte: 0, 1 or 2
   typedef struct packed {
      logic [1:0] num;
      entry_type  e0;
      entry_type  e1;
   } result_type;

endpackage

@@ rtl/utf8d_decode.sv @@
// Sequence decoder: decode state, replacement register and per-byte unit logic.
// Depends on utf8d_pkg.
module utf8d_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [utf8d_pkg::UNIT_W-1:0]        csr_wdata,
   input  logic                                accept,
   input  logic [utf8d_pkg::BYTE_W-1:0]        byte_in,
   input  logic                                stream_last,
   output utf8d_pkg::result_type               result
);

   logic [utf8d_pkg::UNIT_W-1:0] repl_ff;
   logic [utf8d_pkg::CNT_W-1:0]  left_ff,  left_in;
   logic [utf8d_pkg::BYTE_W-1:0] lead_ff,  lead_in;
   logic [utf8d_pkg::CNT_W-1:0]  pos_ff,   pos_in;
   logic [utf8d_pkg::CP_W-1:0]   acc_ff,   acc_in;
   logic                         err_ff,   err_in;

   logic [utf8d_pkg::BYTE_W-1:0] lo, hi;
   logic [utf8d_pkg::CP_W-1:0]   acc_next, supp;
   logic                         err_next;
   logic [utf8d_pkg::CNT_W-1:0]  left_next;
   logic [1:0]                   num;
   logic [utf8d_pkg::UNIT_W-1:0] u0, u1;

   always_comb begin
      lo        = utf8d_pkg::CONT_LO;
      hi        = utf8d_pkg::CONT_HI;
      if (pos_ff == 2'd1) begin
         if (lead_ff == utf8d_pkg::LEAD3_MIN) begin
            lo = utf8d_pkg::E0_LO;
         end else if (lead_ff == utf8d_pkg::LEAD4_MIN) begin
            lo = utf8d_pkg::F0_LO;
         end else if (lead_ff == utf8d_pkg::LEAD4_MAX) begin
            hi = utf8d_pkg::F4_HI;
         end
      end
      err_next  = err_ff | (byte_in < lo) | (byte_in > hi);
      acc_next  = {acc_ff[utf8d_pkg::CP_W-7:0], byte_in[5:0]};
      left_next = left_ff - 2'd1;
      supp      = acc_next - utf8d_pkg::SUPP_BASE;

      left_in = left_ff;
      lead_in = lead_ff;
      pos_in  = pos_ff;
      acc_in  = acc_ff;
      err_in  = err_ff;
      num     = 2'd0;
      u0      = repl_ff;
      u1      = repl_ff;

      if (left_ff == '0) begin
         if (byte_in <= utf8d_pkg::ASCII_MAX) begin
            num = 2'd1;
            u0  = {8'h00, byte_in};
         end else if (byte_in >= utf8d_pkg::LEAD2_MIN && byte_in <= utf8d_pkg::LEAD2_MAX) begin
            left_in = 2'd1;
            acc_in  = {16'h0000, byte_in[4:0]};
         end else if (byte_in >= utf8d_pkg::LEAD3_MIN && byte_in <= utf8d_pkg::LEAD3_MAX) begin
            left_in = 2'd2;
            acc_in  = {17'h00000, byte_in[3:0]};
         end else if (byte_in >= utf8d_pkg::LEAD4_MIN && byte_in <= utf8d_pkg::LEAD4_MAX) begin
            left_in = 2'd3;
            acc_in  = {18'h00000, byte_in[2:0]};
         end else begin
            num = 2'd1;
         end
         if (left_in != '0) begin
            lead_in = byte_in;
            pos_in  = 2'd1;
            err_in  = 1'b0;
            if (stream_last) begin
               num     = 2'd1;
               left_in = '0;
               lead_in = '0;
               pos_in  = '0;
               acc_in  = '0;
            end
         end
      end else begin
         left_in = left_next;
         pos_in  = pos_ff + 2'd1;
         acc_in  = acc_next;
         err_in  = err_next;
         if (left_next == '0 || stream_last) begin
            num = 2'd1;
            if (left_next == '0 && !err_next) begin
               if (acc_next[utf8d_pkg::CP_W-1:16] != '0) begin
                  num = 2'd2;
                  u0  = utf8d_pkg::HI_SURR | {6'd0, supp[19:10]};
                  u1  = utf8d_pkg::LO_SURR | {6'd0, acc_next[9:0]};
               end else begin
                  u0  = acc_next[15:0];
               end
            end
            left_in = '0;
            lead_in = '0;
            pos_in  = '0;
            acc_in  = '0;
            err_in  = 1'b0;
         end
      end

      result.num           = num;
      result.e0.code_unit  = u0;
      result.e0.run_last   = (num == 2'd1);
      result.e0.stream_end = (num == 2'd1) & stream_last;
      result.e1.code_unit  = u1;
      result.e1.run_last   = 1'b1;
      result.e1.stream_end = stream_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= utf8d_pkg::REPL_RESET;
         left_ff <= '0;
         lead_ff <= '0;
         pos_ff  <= '0;
         acc_ff  <= '0;
         err_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            repl_ff <= csr_wdata;
         end
         if (accept) begin
            left_ff <= left_in;
            lead_ff <= lead_in;
            pos_ff  <= pos_in;
            acc_ff  <= acc_in;
            err_ff  <= err_in;
         end
      end
   end

endmodule

@@ rtl/utf8d_outq.sv @@
// Result queue: takes up to two units per beat, hands out one per beat.
// Depends on utf8d_pkg.
module utf8d_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  utf8d_pkg::result_type result,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output utf8d_pkg::entry_type  out_entry
);

   utf8d_pkg::entry_type            slot_ff [utf8d_pkg::QDEPTH];
   logic [utf8d_pkg::QPTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [utf8d_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;
   logic [1:0]                      num;
   logic                            pop;
   logic [utf8d_pkg::QPTR_W-1:0]    wr_nxt;

   assign num       = push ? result.num : 2'd0;
   assign pop       = out_valid & out_ready;
   assign wr_nxt    = wr_ff + utf8d_pkg::QPTR_W'(1);
   assign wr_in     = wr_ff + utf8d_pkg::QPTR_W'(num);
   assign rd_in     = rd_ff + utf8d_pkg::QPTR_W'(pop);
   assign cnt_in    = cnt_ff + utf8d_pkg::QCNT_W'(num) - utf8d_pkg::QCNT_W'(pop);
   assign out_valid = (cnt_ff != '0);
   assign out_entry = slot_ff[rd_ff];
   assign room      = (cnt_ff <= utf8d_pkg::QCNT_W'(utf8d_pkg::QDEPTH - 2));

   always_ff @(posedge clock) begin
      if (num != 2'd0) begin
         slot_ff[wr_ff] <= result.e0;
      end
      if (num == 2'd2) begin
         slot_ff[wr_nxt] <= result.e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/utf8_to_utf16_stream_decoder.sv @@
// Top level of the UTF-8 to UTF-16 stream decoder.
// Instantiates utf8d_decode and utf8d_outq; depends on utf8d_pkg.
//
// Usage:
//   req_*  : one UTF-8 byte per beat, req_tlast on the final byte of a string.
//   rsp_*  : one UTF-16 code unit per beat. rsp_tlast marks the last unit
//            caused by an input byte, rsp_tuser the final unit of a string.
//   csr_*  : write of the replacement unit (reset value 16'h003F); write only
//            while the block is idle.
// Latency: a unit caused by a byte is valid on rsp the cycle after that byte's
//   beat when the result queue is empty.
// Throughput: one byte per cycle. A byte yields zero, one or two units; the
//   four-entry result queue drains one unit per cycle and req_tready drops
//   while fewer than two entries are free.
// Reset: synchronous, clears the decode state and empties the queue; the
//   replacement unit returns to '?'.
// Stall: while rsp_tready is low the head unit holds; bytes keep being taken
//   until the queue is nearly full.
module utf8_to_utf16_stream_decoder (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [utf8d_pkg::TDATA_IN_W-1:0]       req_tdata,  // [7:0] byte_in
   input  logic                                   req_tlast,  // stream_last
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [utf8d_pkg::TDATA_OUT_W-1:0]      rsp_tdata,  // [15:0] code_unit
   output logic                                   rsp_tlast,  // run_last
   output logic                                   rsp_tuser,  // [0] stream_end
   input  logic                                   csr_we,
   input  logic [utf8d_pkg::UNIT_W-1:0]           csr_wdata   // replacement_unit
);

   logic                  accept;
   logic                  room;
   utf8d_pkg::result_type result;
   utf8d_pkg::entry_type  head;

   assign req_tready = room;
   assign accept     = req_tvalid & room;

   utf8d_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .byte_in     (req_tdata[utf8d_pkg::BYTE_W-1:0]),
      .stream_last (req_tlast),
      .result      (result)
   );

   utf8d_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .result    (result),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (head)
   );

   assign rsp_tdata = head.code_unit;
   assign rsp_tlast = head.run_last;
   assign rsp_tuser = head.stream_end;

endmodule

@@ rtl/utf8d_checker.sv @@
// Port-level checks for utf8_to_utf16_stream_decoder, bound to the top level.
// Depends on utf8d_pkg.
module utf8d_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [utf8d_pkg::TDATA_OUT_W-1:0]   rsp_tdata,
   input logic                                rsp_tlast,
   input logic                                rsp_tuser
);

   // held beat on a stalled rsp
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // string end is always the last unit of its byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream end without run end");

   // after reset the queue is empty and bytes are taken
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("queue not empty after reset");

   // back-pressure only while units are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with nothing to deliver");

endmodule

bind utf8_to_utf16_stream_decoder utf8d_checker u_utf8d_checker (.*);
